// ===== src/pti_pkg.sv =====
`default_nettype none

package pti_pkg;

  localparam int unsigned OUT_INDEX_W = 16;
  localparam int unsigned STRIP_LEN_W = 7;
  localparam int unsigned MODE_W      = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_TRI   = 2'd0,
    MODE_QUAD  = 2'd1,
    MODE_STRIP = 2'd2
  } mode_e;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } state_e;

  typedef struct packed {
    logic load;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic emits;
    logic at_last;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== src/primitive_to_triangle_indices_unit.sv =====
// Primitive to triangle-list index expander.
// Input stream (s_axis): one transaction per mesh primitive; tuser carries
// first_of_mesh, tdata carries strip_length (used in strip mode only).
// Output stream (m_axis): one transaction per triangle; tdata carries the three
// indices, tlast marks the final triangle of the primitive.
// Config channel (cfg_*): primitive_mode, 0 triangles, 1 quads, 2 strips;
// write only while the unit is idle. cfg_ready_o is always high.
// Flow: a primitive is taken from the input, then one triangle is loaded into
// the output register per cycle while that register is free: 1 for triangles,
// 2 for quads, length-2 for strips. A primitive that yields nothing (short
// strip, unused mode) is taken without entering the emit state. The first
// m_axis_tvalid rises after the input transaction has passed through the state
// register and the output register, later while that register is still held.
// The emit counter and the single output register set this pace.
// A stalled receiver holds the output register and pauses the emit counter;
// s_axis_tready stays low until the last triangle is in the output register.
// Reset clears the mode to triangles, the vertex base to zero and empties the
// output register.
`default_nettype none

module primitive_to_triangle_indices_unit #(
  parameter int unsigned MAX_STRIP  = 64,
  parameter int unsigned INDEX_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_data_i,      // primitive_mode
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,    // [6:0] strip_length, [7] zero
  input  wire logic [0:0]  s_axis_tuser,    // [0] first_of_mesh
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,    // [15:0] first, [31:16] second, [47:32] third
  output logic             m_axis_tlast     // last_of_primitive
);
  import pti_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  pti_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pti_datapath #(
    .MAX_STRIP  (MAX_STRIP),
    .INDEX_BITS (INDEX_BITS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_valid_i),
    .cfg_mode_i          (cfg_data_i),
    .first_of_mesh_i     (s_axis_tuser[0]),
    .strip_length_i      (s_axis_tdata[STRIP_LEN_W-1:0]),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .out_valid_o         (m_axis_tvalid),
    .out_ready_i         (m_axis_tready),
    .index_first_o       (m_axis_tdata[15:0]),
    .index_second_o      (m_axis_tdata[31:16]),
    .index_third_o       (m_axis_tdata[47:32]),
    .last_of_primitive_o (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== src/pti_ctrl.sv =====
`default_nettype none

module pti_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire pti_pkg::dp_sts_t sts_i,
  output pti_pkg::dp_cmd_t      cmd_o
);
  import pti_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && sts_i.emits) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free && sts_i.at_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.load    = 1'b0;
    cmd_o.advance = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_EMIT: begin
        cmd_o.advance = sts_i.out_free;
      end
      default: ;
    endcase
  end

  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (state_q == ST_IDLE) && !cmd_o.advance)
    else $error("load outside idle");

  a_emit_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load && sts_i.emits) |=> (state_q == ST_EMIT))
    else $error("no emit after producing load");

  a_emit_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.advance && sts_i.at_last) |=> (state_q == ST_IDLE))
    else $error("emit did not end on last triangle");

endmodule

`default_nettype wire

// ===== src/pti_datapath.sv =====
`default_nettype none

module pti_datapath #(
  parameter int unsigned MAX_STRIP  = 64,
  parameter int unsigned INDEX_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [pti_pkg::MODE_W-1:0]        cfg_mode_i,
  input  wire logic                              first_of_mesh_i,
  input  wire logic [pti_pkg::STRIP_LEN_W-1:0]   strip_length_i,
  input  wire pti_pkg::dp_cmd_t                  cmd_i,
  output pti_pkg::dp_sts_t                       sts_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [pti_pkg::OUT_INDEX_W-1:0]        index_first_o,
  output logic [pti_pkg::OUT_INDEX_W-1:0]        index_second_o,
  output logic [pti_pkg::OUT_INDEX_W-1:0]        index_third_o,
  output logic                                   last_of_primitive_o
);
  import pti_pkg::*;

  localparam int unsigned STEP_W = (MAX_STRIP > 2) ? $clog2(MAX_STRIP) : 1;

  logic [MODE_W-1:0]      mode_q;
  logic [INDEX_BITS-1:0]  base_q, base_d;
  logic [INDEX_BITS-1:0]  cur_q;
  logic [STEP_W-1:0]      step_q, step_d;
  logic [STEP_W-1:0]      last_step_q, last_step_d;
  logic                   out_valid_q, out_valid_d;
  logic [OUT_INDEX_W-1:0] idx_a_q, idx_b_q, idx_c_q;
  logic                   last_q;

  logic [INDEX_BITS-1:0]  b_in;
  logic [STRIP_LEN_W-1:0] s_sat;
  logic [INDEX_BITS-1:0]  j, ia, ib, ic;
  logic                   at_last;
  logic                   emits;

  always_comb begin
    b_in  = first_of_mesh_i ? '0 : base_q;
    s_sat = (strip_length_i > STRIP_LEN_W'(MAX_STRIP)) ? STRIP_LEN_W'(MAX_STRIP)
                                                        : strip_length_i;
    emits       = 1'b0;
    base_d      = b_in;
    last_step_d = '0;
    unique case (mode_e'(mode_q))
      MODE_TRI: begin
        emits  = 1'b1;
        base_d = b_in + INDEX_BITS'(3);
      end
      MODE_QUAD: begin
        emits       = 1'b1;
        base_d      = b_in + INDEX_BITS'(4);
        last_step_d = STEP_W'(1);
      end
      MODE_STRIP: begin
        emits       = (s_sat >= STRIP_LEN_W'(3));
        base_d      = b_in + INDEX_BITS'(s_sat);
        last_step_d = STEP_W'(s_sat - STRIP_LEN_W'(3));
      end
      default: ;
    endcase
  end

  assign at_last = (step_q == last_step_q);
  assign sts_o   = '{emits: emits, at_last: at_last, out_free: (!out_valid_q || out_ready_i)};

  always_comb begin
    j  = cur_q + INDEX_BITS'(step_q);
    ia = cur_q;
    ib = cur_q + INDEX_BITS'(1);
    ic = cur_q + INDEX_BITS'(2);
    unique case (mode_e'(mode_q))
      MODE_QUAD: begin
        if (step_q[0]) begin
          ib = cur_q + INDEX_BITS'(2);
          ic = cur_q + INDEX_BITS'(3);
        end
      end
      MODE_STRIP: begin
        ic = j + INDEX_BITS'(2);
        if (step_q[0]) begin
          ia = j + INDEX_BITS'(1);
          ib = j;
        end else begin
          ia = j;
          ib = j + INDEX_BITS'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (cmd_i.load) begin
      step_d = '0;
    end else if (cmd_i.advance) begin
      step_d = step_q + STEP_W'(1);
    end
    if (cmd_i.advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_TRI;
      base_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_mode_i;
      end
      if (cmd_i.load) begin
        base_q <= base_d;
      end
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_q       <= b_in;
      last_step_q <= last_step_d;
    end
    if (cmd_i.advance) begin
      idx_a_q <= OUT_INDEX_W'(ia);
      idx_b_q <= OUT_INDEX_W'(ib);
      idx_c_q <= OUT_INDEX_W'(ic);
      last_q  <= at_last;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign index_first_o       = idx_a_q;
  assign index_second_o      = idx_b_q;
  assign index_third_o       = idx_c_q;
  assign last_of_primitive_o = last_q;

  a_step_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> (step_q == '0))
    else $error("step not cleared on load");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.advance |-> (step_q <= last_step_q))
    else $error("step ran past last triangle");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !cmd_i.advance)
    else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

// ===== tb/primitive_to_triangle_indices_unit_tb.sv =====
`default_nettype none

module primitive_to_triangle_indices_unit_tb;
  import pti_pkg::*;

  localparam int unsigned STRIP_CAP = 64;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic [OUT_INDEX_W-1:0] first_idx;
    logic [OUT_INDEX_W-1:0] second_idx;
    logic [OUT_INDEX_W-1:0] third_idx;
    logic                   last;
  } triangle_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [6:0] strip_length, [7] zero
  logic [0:0]  s_axis_tuser;   // [0] first_of_mesh
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // [15:0] first, [31:16] second, [47:32] third
  logic        m_axis_tlast;

  primitive_to_triangle_indices_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  logic [MODE_W-1:0]      mode_q;
  logic [OUT_INDEX_W-1:0] base_q;
  triangle_t              pending_triangles[$];
  int unsigned            error_count;
  int unsigned            src_idle_pct;
  int unsigned            sink_stall_pct;
  int unsigned            sink_hold_left;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #30_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic push_triangle(input logic [OUT_INDEX_W-1:0] a, input logic [OUT_INDEX_W-1:0] b,
                               input logic [OUT_INDEX_W-1:0] c, input logic last);
    triangle_t t;
    t.first_idx  = a;
    t.second_idx = b;
    t.third_idx  = c;
    t.last       = last;
    pending_triangles = {pending_triangles, t};
  endtask

  task automatic expand_primitive(input logic first, input logic [STRIP_LEN_W-1:0] len);
    logic [OUT_INDEX_W-1:0] b;
    logic [OUT_INDEX_W-1:0] j;
    logic [STRIP_LEN_W-1:0] s;
    if (first) base_q = '0;
    b = base_q;
    case (mode_q)
      MODE_TRI: begin
        push_triangle(b, b + 16'd1, b + 16'd2, 1'b1);
        base_q = b + 16'd3;
      end
      MODE_QUAD: begin
        push_triangle(b, b + 16'd1, b + 16'd2, 1'b0);
        push_triangle(b, b + 16'd2, b + 16'd3, 1'b1);
        base_q = b + 16'd4;
      end
      MODE_STRIP: begin
        s = (len > STRIP_LEN_W'(STRIP_CAP)) ? STRIP_LEN_W'(STRIP_CAP) : len;
        for (int k = 0; k + 2 < s; k++) begin
          j = b + OUT_INDEX_W'(k);
          if (k % 2 == 0) push_triangle(j, j + 16'd1, j + 16'd2, k + 3 == s);
          else push_triangle(j + 16'd1, j, j + 16'd2, k + 3 == s);
        end
        base_q = b + OUT_INDEX_W'(s);
      end
      default: ;
    endcase
  endtask

  // result checker
  always @(posedge clk_i) begin
    triangle_t t;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_triangles.size() == 0) begin
        report_mismatch($sformatf("unexpected triangle %h last %b", m_axis_tdata, m_axis_tlast));
      end else begin
        t = pending_triangles.pop_front();
        if (m_axis_tdata[15:0] !== t.first_idx)
          report_mismatch($sformatf("index_first %h, want %h", m_axis_tdata[15:0], t.first_idx));
        if (m_axis_tdata[31:16] !== t.second_idx)
          report_mismatch($sformatf("index_second %h, want %h", m_axis_tdata[31:16],
                                    t.second_idx));
        if (m_axis_tdata[47:32] !== t.third_idx)
          report_mismatch($sformatf("index_third %h, want %h", m_axis_tdata[47:32], t.third_idx));
        if (m_axis_tlast !== t.last)
          report_mismatch($sformatf("last_of_primitive %b, want %b", m_axis_tlast, t.last));
      end
    end
  end

  // receiver: long hold first, then random stalls
  always @(negedge clk_i) begin
    if (sink_hold_left > 0) begin
      m_axis_tready = 1'b0;
      sink_hold_left--;
    end else begin
      m_axis_tready = ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic send_primitive(input logic first, input logic [STRIP_LEN_W-1:0] len);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  = {1'b0, len};
    s_axis_tuser  = first;
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expand_primitive(first, len);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (pending_triangles.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_mode(input logic [MODE_W-1:0] m);
    wait_idle();
    cfg_data_i  = m;
    cfg_valid_i = 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    mode_q = m;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [STRIP_LEN_W-1:0] rand_strip_len();
    int unsigned r;
    r = $urandom_range(15);
    if (r == 0) return STRIP_LEN_W'($urandom_range(65, 127));
    if (r == 1) return STRIP_LEN_W'($urandom_range(3, 64));
    return STRIP_LEN_W'($urandom_range(0, 12));
  endfunction

  task automatic test_reset_mode();
    // no config write: triangle list is the reset mode
    send_primitive(1'b0, 7'd0);
    send_primitive(1'b0, 7'd127);
    send_primitive(1'b1, 7'd5);
    send_primitive(1'b0, 7'd64);
  endtask

  task automatic test_quads();
    write_mode(MODE_QUAD);
    send_primitive(1'b0, 7'd3);
    send_primitive(1'b1, 7'd127);
    send_primitive(1'b0, 7'd0);
  endtask

  task automatic test_strips();
    write_mode(MODE_STRIP);
    // short strips emit nothing but still move the base
    send_primitive(1'b1, 7'd0);
    send_primitive(1'b0, 7'd1);
    send_primitive(1'b0, 7'd2);
    send_primitive(1'b0, 7'd3);
    send_primitive(1'b0, 7'd4);
    send_primitive(1'b0, 7'd5);
    send_primitive(1'b0, 7'd64);
    // overlong strips saturate
    send_primitive(1'b0, 7'd65);
    send_primitive(1'b1, 7'd127);
    send_primitive(1'b0, 7'd6);
  endtask

  task automatic test_unused_mode();
    write_mode(MODE_UNUSED);
    send_primitive(1'b0, 7'd10);
    send_primitive(1'b1, 7'd127);
    write_mode(MODE_TRI);
    send_primitive(1'b0, 7'd0);
  endtask

  task automatic test_long_strips();
    write_mode(MODE_STRIP);
    send_primitive(1'b1, 7'd1);
    repeat (16) send_primitive(1'b0, STRIP_LEN_W'($urandom_range(64, 127)));
    write_mode(MODE_QUAD);
    send_primitive(1'b0, 7'd0);
  endtask

  task automatic test_backpressure();
    write_mode(MODE_STRIP);
    sink_hold_left = 200;
    repeat (12) send_primitive($urandom_range(1) == 0, STRIP_LEN_W'($urandom_range(3, 12)));
    // sender pauses until every triangle has drained
    wait_idle();
    repeat (4) send_primitive(1'b0, STRIP_LEN_W'($urandom_range(3, 8)));
  endtask

  task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                  input int unsigned n_items);
    int unsigned       sent;
    int unsigned       r;
    logic [MODE_W-1:0] m;
    sent = 0;
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    while (sent < n_items) begin
      r = $urandom_range(9);
      if (r < 2) m = MODE_TRI;
      else if (r < 4) m = MODE_QUAD;
      else if (r < 9) m = MODE_STRIP;
      else m = MODE_UNUSED;
      write_mode(m);
      repeat ($urandom_range(8, 20)) begin
        send_primitive($urandom_range(7) == 0,
                       (m == MODE_STRIP) ? rand_strip_len()
                                         : STRIP_LEN_W'($urandom_range(127)));
        sent++;
      end
    end
    wait_idle();
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    m_axis_tready  = 1'b0;
    mode_q         = MODE_TRI;
    base_q         = '0;
    error_count    = 0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    sink_hold_left = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_mode();
    test_quads();
    test_strips();
    test_unused_mode();
    test_long_strips();
    test_backpressure();
    run_random_phase(0, 0, 70);
    run_random_phase(77, 0, 70);
    run_random_phase(0, 77, 70);
    run_random_phase(34, 34, 70);

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
src/pti_pkg.sv
src/pti_ctrl.sv
src/pti_datapath.sv
src/primitive_to_triangle_indices_unit.sv
tb/primitive_to_triangle_indices_unit_tb.sv
